// ===== design/hrsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrsc_pkg: heater run state controller shared definitions
// Types, codes and constants used by the channel interfaces and the controller.
// ----------------------------------------------------------------------------
package hrsc_pkg;

	localparam int unsigned TICK_W  = 21;
	localparam int unsigned COUNT_W = 32;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(30 * 60 * 1000);

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_STOP   = 3'd1;
	localparam logic [2:0] OP_LOW    = 3'd2;
	localparam logic [2:0] OP_MEDIUM = 3'd3;
	localparam logic [2:0] OP_HIGH   = 3'd4;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_HEAT = 2'd1,
		MODE_ERR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		LEVEL_LOW    = 2'd0,
		LEVEL_MEDIUM = 2'd1,
		LEVEL_HIGH   = 2'd2
	} level_t;

	typedef struct packed {
		logic [2:0] op;
		logic       press_confirmed;
		logic       calibration_valid;
		logic       overcurrent_tripped;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         run_state;
		logic [1:0]         power_level;
		logic               drive_enable;
		logic               trip_clear;
		logic               beep;
		logic [COUNT_W-1:0] stop_presses;
		logic [COUNT_W-1:0] low_presses;
		logic [COUNT_W-1:0] medium_presses;
		logic [COUNT_W-1:0] high_presses;
		logic [TICK_W-1:0]  elapsed;
	} out_item_t;

endpackage

// ===== design/hrsc_if.sv =====
// ----------------------------------------------------------------------------
// hrsc_if: heater run state controller channels
// Valid/ready channels for event transactions and result transactions.
// ----------------------------------------------------------------------------
interface hrsc_in_if;
	logic              valid;
	logic              ready;
	hrsc_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface hrsc_out_if;
	logic               valid;
	logic               ready;
	hrsc_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// ===== design/heater_run_state_controller_unit.sv =====
// ----------------------------------------------------------------------------
// heater_run_state_controller_unit: induction heater run controller
// Event transactions pass through an input register, a combinational state update
// and a result register. Throughput: one transaction per cycle while the result side
// is not stalled; a held result also holds a full input register in that cycle.
// Reset: run state off, level low, elapsed and press counters zero, timeout
// 1800000 ticks.
// ----------------------------------------------------------------------------
module heater_run_state_controller_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	hrsc_in_if.sink                    evt,
	hrsc_out_if.source                 res,
	input  logic                       timeout_we,
	input  logic [hrsc_pkg::TICK_W-1:0] timeout_wdata
);
	import hrsc_pkg::*;

	logic               valid_s1;
	in_item_t           item_s1;
	logic               res_valid_q;
	out_item_t          res_item_q;
	logic               advance;
	logic               fire_s1;

	logic [TICK_W-1:0]  timeout_q;
	mode_t              mode_q;
	level_t             level_q;
	logic [TICK_W-1:0]  heat_q;
	logic [COUNT_W-1:0] stop_q;
	logic [COUNT_W-1:0] low_q;
	logic [COUNT_W-1:0] medium_q;
	logic [COUNT_W-1:0] high_q;

	mode_t              mode_n;
	level_t             level_n;
	logic [TICK_W-1:0]  heat_n;
	logic [COUNT_W-1:0] stop_n;
	logic [COUNT_W-1:0] low_n;
	logic [COUNT_W-1:0] medium_n;
	logic [COUNT_W-1:0] high_n;
	logic               clr_n;
	logic               beep_n;
	logic [TICK_W-1:0]  ticks_inc;
	logic               start_ok;

	assign advance   = !res_valid_q || res.ready;
	assign fire_s1   = valid_s1 && advance;
	assign evt.ready = !valid_s1 || advance;
	assign res.valid = res_valid_q;
	assign res.item  = res_item_q;

	assign ticks_inc = heat_q + TICK_W'(1);
	assign start_ok  = (mode_q == MODE_OFF) && item_s1.calibration_valid;

	always_comb begin
		mode_n   = mode_q;
		level_n  = level_q;
		heat_n   = heat_q;
		stop_n   = stop_q;
		low_n    = low_q;
		medium_n = medium_q;
		high_n   = high_q;
		clr_n    = 1'b0;
		beep_n   = 1'b0;
		case (item_s1.op)
			OP_TICK: begin
				if (mode_q == MODE_HEAT) begin
					if (item_s1.overcurrent_tripped) begin
						mode_n = MODE_ERR;
					end else if (ticks_inc >= timeout_q) begin
						mode_n = MODE_OFF;
						heat_n = '0;
					end else begin
						heat_n = ticks_inc;
					end
				end
			end
			OP_STOP: begin
				if (item_s1.press_confirmed) begin
					beep_n = 1'b1;
					stop_n = stop_q + COUNT_W'(1);
					if (mode_q != MODE_OFF) begin
						clr_n  = (mode_q == MODE_ERR);
						mode_n = MODE_OFF;
						heat_n = '0;
					end
				end
			end
			OP_LOW: begin
				if (item_s1.press_confirmed) begin
					beep_n = 1'b1;
					low_n  = low_q + COUNT_W'(1);
					if (start_ok) begin
						level_n = LEVEL_LOW;
						mode_n  = MODE_HEAT;
						heat_n  = '0;
					end
				end
			end
			OP_MEDIUM: begin
				if (item_s1.press_confirmed) begin
					beep_n   = 1'b1;
					medium_n = medium_q + COUNT_W'(1);
					if (start_ok) begin
						level_n = LEVEL_MEDIUM;
						mode_n  = MODE_HEAT;
						heat_n  = '0;
					end
				end
			end
			OP_HIGH: begin
				if (item_s1.press_confirmed) begin
					beep_n = 1'b1;
					high_n = high_q + COUNT_W'(1);
					if (start_ok) begin
						level_n = LEVEL_HIGH;
						mode_n  = MODE_HEAT;
						heat_n  = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			mode_q      <= MODE_OFF;
			level_q     <= LEVEL_LOW;
			heat_q      <= '0;
			stop_q      <= '0;
			low_q       <= '0;
			medium_q    <= '0;
			high_q      <= '0;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (timeout_we) begin
				timeout_q <= timeout_wdata;
			end
			if (fire_s1) begin
				mode_q   <= mode_n;
				level_q  <= level_n;
				heat_q   <= heat_n;
				stop_q   <= stop_n;
				low_q    <= low_n;
				medium_q <= medium_n;
				high_q   <= high_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1 <= evt.item;
		end
		if (fire_s1) begin
			res_item_q.run_state      <= mode_n;
			res_item_q.power_level    <= level_n;
			res_item_q.drive_enable   <= (mode_n == MODE_HEAT);
			res_item_q.trip_clear     <= clr_n;
			res_item_q.beep           <= beep_n;
			res_item_q.stop_presses   <= stop_n;
			res_item_q.low_presses    <= low_n;
			res_item_q.medium_presses <= medium_n;
			res_item_q.high_presses   <= high_n;
			res_item_q.elapsed        <= heat_n;
		end
	end

	a_drive_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_item_q.drive_enable == (res_item_q.run_state == MODE_HEAT)))
		else $error("drive enable disagrees with run state");

	a_trip_clear_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_item_q.trip_clear) |->
			(res_item_q.beep && res_item_q.run_state == MODE_OFF))
		else $error("trip clear without a stop to off");

	a_off_has_no_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_item_q.run_state == MODE_OFF) |-> (res_item_q.elapsed == '0))
		else $error("elapsed ticks left over in off state");

endmodule

// ===== sim/heater_run_state_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_run_state_controller_unit_test: run controller self-checking bench
// Feeds tick and button event transactions through a bursty driver, stalls
// the result side on shifting patterns, predicts every result transaction
// from a local copy of the controller state and timeout, and checks each
// field in order. Several timeout settings are covered, including zero, one,
// the maximum and a timeout lowered while heating.
// ----------------------------------------------------------------------------
module heater_run_state_controller_unit_test;
	import hrsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 300;

	logic clk;
	logic arst_n;
	logic timeout_we;
	logic [TICK_W-1:0] timeout_wdata;

	hrsc_in_if  evt_if ();
	hrsc_out_if res_if ();

	heater_run_state_controller_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt           (evt_if),
		.res           (res_if),
		.timeout_we    (timeout_we),
		.timeout_wdata (timeout_wdata)
	);

	// controller state as predicted
	mode_t              heat_mode     = MODE_OFF;
	level_t             heat_level    = LEVEL_LOW;
	logic [TICK_W-1:0]  heat_count    = '0;
	logic [TICK_W-1:0]  timeout_limit = TIMEOUT_RESET;
	logic [COUNT_W-1:0] stop_total    = '0;
	logic [COUNT_W-1:0] low_total     = '0;
	logic [COUNT_W-1:0] medium_total  = '0;
	logic [COUNT_W-1:0] high_total    = '0;

	in_item_t  pending_events[$];
	out_item_t expected_results[$];

	int items_sent      = 0;
	int results_checked = 0;
	int error_count     = 0;
	int config_writes   = 0;
	int starts_seen     = 0;
	int trips_seen      = 0;
	int shutoffs_seen   = 0;

	bit evt_taken  = 1'b0;
	int gap_left   = 0;
	int burst_left = 0;

	int stall_token = 0;
	int stall_seen  = 0;
	int hold_off    = 0;
	int stall_style = 0;
	int style_left  = 0;
	logic [7:0] stall_mask = 8'hff;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void start_heating(level_t lvl, logic cal_ok);
		if (heat_mode == MODE_OFF && cal_ok) begin
			heat_level = lvl;
			heat_mode  = MODE_HEAT;
			heat_count = '0;
			starts_seen++;
		end
	endfunction

	function automatic out_item_t predict_heater(in_item_t ev);
		out_item_t r;
		logic clr;
		logic bz;
		clr = 1'b0;
		bz  = 1'b0;
		if (ev.op == OP_TICK) begin
			if (heat_mode == MODE_HEAT) begin
				if (ev.overcurrent_tripped) begin
					heat_mode = MODE_ERR;
					trips_seen++;
				end else begin
					heat_count = heat_count + 1'b1;
					if (heat_count >= timeout_limit) begin
						heat_mode  = MODE_OFF;
						heat_count = '0;
						shutoffs_seen++;
					end
				end
			end
		end else if (ev.op <= OP_HIGH && ev.press_confirmed) begin
			bz = 1'b1;
			case (ev.op)
				OP_STOP: begin
					stop_total++;
					if (heat_mode != MODE_OFF) begin
						clr        = (heat_mode == MODE_ERR);
						heat_mode  = MODE_OFF;
						heat_count = '0;
					end
				end
				OP_LOW: begin
					low_total++;
					start_heating(LEVEL_LOW, ev.calibration_valid);
				end
				OP_MEDIUM: begin
					medium_total++;
					start_heating(LEVEL_MEDIUM, ev.calibration_valid);
				end
				default: begin
					high_total++;
					start_heating(LEVEL_HIGH, ev.calibration_valid);
				end
			endcase
		end
		r.run_state      = heat_mode;
		r.power_level    = heat_level;
		r.drive_enable   = (heat_mode == MODE_HEAT);
		r.trip_clear     = clr;
		r.beep           = bz;
		r.stop_presses   = stop_total;
		r.low_presses    = low_total;
		r.medium_presses = medium_total;
		r.high_presses   = high_total;
		r.elapsed        = heat_count;
		return r;
	endfunction

	function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			error_count++;
		end
	endfunction

	function automatic void queue_event(logic [2:0] op, logic conf, logic cal, logic trip);
		in_item_t ev;
		ev.op                  = op;
		ev.press_confirmed     = conf;
		ev.calibration_valid   = cal;
		ev.overcurrent_tripped = trip;
		pending_events.push_back(ev);
		items_sent++;
	endfunction

	function automatic void queue_random_event();
		int pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			op = OP_TICK;
		else if (pick < 62)
			op = OP_STOP;
		else if (pick < 72)
			op = OP_LOW;
		else if (pick < 82)
			op = OP_MEDIUM;
		else if (pick < 92)
			op = OP_HIGH;
		else
			op = OP_HIGH + 3'($urandom_range(1, 3));
		queue_event(op, $urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0,
			$urandom_range(0, 24) == 0);
	endfunction

	// input acceptance, prediction and result checking
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				got = res_if.item;
				results_checked++;
				if (expected_results.size() == 0) begin
					$display("%0t: result transaction with none expected, actual state %0d elapsed %0d",
						$time, got.run_state, got.elapsed);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("run_state", want.run_state, got.run_state);
					compare_field("power_level", want.power_level, got.power_level);
					compare_field("drive_enable", want.drive_enable, got.drive_enable);
					compare_field("trip_clear", want.trip_clear, got.trip_clear);
					compare_field("beep", want.beep, got.beep);
					compare_field("stop_presses", want.stop_presses, got.stop_presses);
					compare_field("low_presses", want.low_presses, got.low_presses);
					compare_field("medium_presses", want.medium_presses, got.medium_presses);
					compare_field("high_presses", want.high_presses, got.high_presses);
					compare_field("elapsed", want.elapsed, got.elapsed);
				end
			end
			if (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
				expected_results.push_back(predict_heater(evt_if.item));
				evt_taken = 1'b1;
			end
		end
	end

	// event driver: bursts with gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (evt_if.valid && !evt_taken) begin
				// hold
			end else if (gap_left > 0) begin
				gap_left--;
				evt_if.valid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				evt_if.item  <= pending_events.pop_front();
				evt_if.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					burst_left = $urandom_range(20, 60);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left   = $urandom_range(1, 6);
				end
			end else begin
				evt_if.valid <= 1'b0;
			end
			evt_taken = 1'b0;
		end
	end

	// result receiver: shifting stall patterns, long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_seen != stall_token) begin
				stall_seen = stall_token;
				hold_off   = LONG_STALL;
			end
			if (hold_off > 0) begin
				hold_off--;
				res_if.ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					stall_style = $urandom_range(0, 3);
					style_left  = $urandom_range(16, 80);
					stall_mask  = 8'($urandom) | 8'h01;
				end else begin
					style_left--;
				end
				case (stall_style)
					0: res_if.ready <= 1'b1;
					1: res_if.ready <= ($urandom_range(0, 3) != 0);
					2: begin
						stall_mask = {stall_mask[6:0], stall_mask[7]};
						res_if.ready <= stall_mask[0];
					end
					default: res_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
			@(posedge clk);
		$display("%0t: timeout after %0d cycles, %0d of %0d results seen",
			$time, CYCLE_LIMIT, results_checked, items_sent);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic wait_idle();
		while (results_checked < items_sent)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(logic [TICK_W-1:0] value);
		@(negedge clk);
		timeout_we    <= 1'b1;
		timeout_wdata <= value;
		@(negedge clk);
		timeout_we    <= 1'b0;
		timeout_limit = value;
		config_writes++;
	endtask

	task automatic run_random_phase(logic [TICK_W-1:0] limit, int count, bit long_stall);
		write_timeout(limit);
		repeat (count) queue_random_event();
		if (long_stall)
			stall_token++;
		wait_idle();
	endtask

	initial begin
		arst_n        = 1'b0;
		timeout_we    = 1'b0;
		timeout_wdata = '0;
		evt_if.valid  = 1'b0;
		evt_if.item   = '0;
		res_if.ready  = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		write_timeout(TICK_W'(3));
		queue_event(OP_TICK, 1'b1, 1'b1, 1'b1);
		queue_event(OP_HIGH + 3'd1, 1'b1, 1'b1, 1'b0);
		queue_event(OP_HIGH + 3'd2, 1'b1, 1'b0, 1'b1);
		queue_event(OP_HIGH + 3'd3, 1'b1, 1'b1, 1'b1);
		queue_event(OP_STOP, 1'b0, 1'b1, 1'b0);
		queue_event(OP_STOP, 1'b1, 1'b0, 1'b0);
		queue_event(OP_LOW, 1'b0, 1'b1, 1'b0);
		queue_event(OP_LOW, 1'b1, 1'b0, 1'b0);
		queue_event(OP_MEDIUM, 1'b1, 1'b1, 1'b0);
		queue_event(OP_HIGH, 1'b1, 1'b1, 1'b0);
		queue_event(OP_TICK, 1'b0, 1'b0, 1'b0);
		queue_event(OP_TICK, 1'b1, 1'b1, 1'b1);
		queue_event(OP_TICK, 1'b0, 1'b0, 1'b0);
		queue_event(OP_LOW, 1'b1, 1'b1, 1'b0);
		queue_event(OP_STOP, 1'b1, 1'b1, 1'b1);
		queue_event(OP_HIGH, 1'b1, 1'b1, 1'b0);
		queue_event(OP_TICK, 1'b0, 1'b1, 1'b0);
		queue_event(OP_TICK, 1'b1, 1'b0, 1'b0);
		queue_event(OP_TICK, 1'b0, 1'b0, 1'b0);
		queue_event(OP_LOW, 1'b1, 1'b1, 1'b0);
		queue_event(OP_STOP, 1'b1, 1'b1, 1'b0);
		wait_idle();

		write_timeout('0);
		queue_event(OP_MEDIUM, 1'b1, 1'b1, 1'b0);
		queue_event(OP_TICK, 1'b0, 1'b0, 1'b0);
		wait_idle();

		write_timeout(TICK_W'(8));
		queue_event(OP_HIGH, 1'b1, 1'b1, 1'b0);
		repeat (6) queue_event(OP_TICK, 1'b0, 1'b0, 1'b0);
		wait_idle();
		write_timeout(TICK_W'(2));
		queue_event(OP_TICK, 1'b0, 1'b0, 1'b0);
		wait_idle();

		run_random_phase(TICK_W'($urandom_range(4, 30)), 280, 1'b1);
		run_random_phase(TICK_W'(1), 270, 1'b0);
		run_random_phase({TICK_W{1'b1}}, 270, 1'b0);
		run_random_phase(TIMEOUT_RESET, 270, 1'b0);
		repeat (10) @(negedge clk);

		$display("Sent %0d event transactions, checked %0d results over %0d timeout writes.",
			items_sent, results_checked, config_writes);
		$display("Saw %0d heating starts, %0d over-current trips and %0d timeout shutoffs.",
			starts_seen, trips_seen, shutoffs_seen);
		if (error_count == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/hrsc_pkg.sv
design/hrsc_if.sv
design/heater_run_state_controller_unit.sv
sim/heater_run_state_controller_unit_test.sv
